// ===== rtl/gpio_lk_pkg.sv =====
// Package with the register codes, constants and shared types of the GPIO port.
`timescale 1ns / 1ps

package gpio_lk_pkg;

	localparam int NPINS = 16;
	localparam int KEY_POS = 16;
	localparam logic [31:0] CFG_RESET = 32'h4444_4444;

	localparam logic OP_READ = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [2:0] IDX_CRL = 3'd0;
	localparam logic [2:0] IDX_CRH = 3'd1;
	localparam logic [2:0] IDX_IDR = 3'd2;
	localparam logic [2:0] IDX_ODR = 3'd3;
	localparam logic [2:0] IDX_BSRR = 3'd4;
	localparam logic [2:0] IDX_BRR = 3'd5;
	localparam logic [2:0] IDX_LCKR = 3'd6;

	// One accepted bus access, already split into read and write strobes.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic [2:0] idx;
		logic [31:0] data;
	} bus_op_t;

	// Lock state seen by the configuration registers.
	typedef struct packed {
		logic [NPINS-1:0] bits;
		logic key;
	} lock_stat_t;

endpackage

// ===== rtl/gpio_lk_ifs.sv =====
// Handshake interfaces for the access and result channels of the GPIO port.
`timescale 1ns / 1ps

interface gpio_lk_req_if;
	logic valid;
	logic ready;
	logic opcode;
	logic [2:0] reg_index;
	logic [31:0] write_data;
	logic [15:0] pin_levels;

	modport source (output valid, output opcode, output reg_index, output write_data,
		output pin_levels, input ready);
	modport sink (input valid, input opcode, input reg_index, input write_data,
		input pin_levels, output ready);
endinterface

interface gpio_lk_rsp_if;
	logic valid;
	logic ready;
	logic [31:0] read_data;
	logic [15:0] pin_out;
	logic [31:0] pin_modes_low;
	logic [31:0] pin_modes_high;
	logic lock_active;

	modport source (output valid, output read_data, output pin_out, output pin_modes_low,
		output pin_modes_high, output lock_active, input ready);
	modport sink (input valid, input read_data, input pin_out, input pin_modes_low,
		input pin_modes_high, input lock_active, output ready);
endinterface

// ===== rtl/gpio_lk_lock.sv =====
// Lock register with its write 1, write 0, write 1, read key sequence.
`timescale 1ns / 1ps

module gpio_lk_lock import gpio_lk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  bus_op_t op,
	output lock_stat_t stat
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_FIRST,
		PH_SECOND,
		PH_THIRD
	} phase_t;

	phase_t phase_q;
	logic [NPINS-1:0] bits_q;
	logic key_q;

	logic lckr_wr;
	logic lckr_rd;
	logic key_in;
	logic match;

	always_comb begin
		lckr_wr = op.wr_en && (op.idx == IDX_LCKR) && !key_q;
		lckr_rd = op.rd_en && (op.idx == IDX_LCKR);
		key_in = op.data[KEY_POS];
		match = (op.data[NPINS-1:0] == bits_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bits_q <= '0;
			key_q <= 1'b0;
		end else if (lckr_wr) begin
			bits_q <= op.data[NPINS-1:0];
			if (phase_q == PH_FIRST && !key_in && match) begin
				phase_q <= PH_SECOND;
			end else if (phase_q == PH_SECOND && key_in && match) begin
				phase_q <= PH_THIRD;
			end else begin
				phase_q <= key_in ? PH_FIRST : PH_IDLE;
			end
		end else if (lckr_rd) begin
			if (phase_q == PH_THIRD) begin
				key_q <= 1'b1;
			end
			phase_q <= PH_IDLE;
		end
	end

	assign stat.bits = bits_q;
	assign stat.key = key_q;

`ifndef NO_ASSERTIONS
	a_key_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		key_q |=> key_q) else $error("lock key dropped without reset");
	a_key_needs_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(key_q) |-> $past(lckr_rd && phase_q == PH_THIRD))
		else $error("lock key set outside the key sequence");
	a_bits_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		key_q |=> $stable(bits_q)) else $error("lock bits changed while locked");
	a_idle_locked: assert property (@(posedge clk) disable iff (!arst_n)
		$past(key_q) && key_q |-> phase_q == PH_IDLE)
		else $error("key sequence moving while locked");
`endif

endmodule

// ===== rtl/gpio_lk_regs.sv =====
// Configuration and output data registers, with the lock mask on the configuration nibbles.
`timescale 1ns / 1ps

module gpio_lk_regs import gpio_lk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  bus_op_t op,
	input  lock_stat_t stat,
	output logic [31:0] crl_q,
	output logic [31:0] crh_q,
	output logic [NPINS-1:0] odr_q
);

	logic [31:0] mask_lo;
	logic [31:0] mask_hi;

	// A locked pin keeps all four bits of its nibble.
	always_comb begin
		for (int p = 0; p < 8; p++) begin
			mask_lo[4*p +: 4] = {4{stat.key & stat.bits[p]}};
			mask_hi[4*p +: 4] = {4{stat.key & stat.bits[p+8]}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crl_q <= CFG_RESET;
			crh_q <= CFG_RESET;
			odr_q <= '0;
		end else if (op.wr_en) begin
			case (op.idx)
				IDX_CRL: crl_q <= (crl_q & mask_lo) | (op.data & ~mask_lo);
				IDX_CRH: crh_q <= (crh_q & mask_hi) | (op.data & ~mask_hi);
				IDX_ODR: odr_q <= op.data[NPINS-1:0];
				IDX_BSRR: odr_q <= (odr_q & ~op.data[31:16]) | op.data[NPINS-1:0];
				IDX_BRR: odr_q <= odr_q & ~op.data[NPINS-1:0];
				default: ;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_locked_low: assert property (@(posedge clk) disable iff (!arst_n)
		stat.key && $past(stat.key) |-> (crl_q & mask_lo) == ($past(crl_q) & mask_lo))
		else $error("locked low nibble changed");
	a_locked_high: assert property (@(posedge clk) disable iff (!arst_n)
		stat.key && $past(stat.key) |-> (crh_q & mask_hi) == ($past(crh_q) & mask_hi))
		else $error("locked high nibble changed");
	a_odr_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		!op.wr_en |=> $stable(odr_q)) else $error("output data changed without a write");
`endif

endmodule

// ===== rtl/gpio_lk_port.sv =====
// Top level of the 16-pin GPIO port with configuration lock.
`timescale 1ns / 1ps

// The port answers one bus access per clock cycle while req.ready is high. An
// access is accepted when req.valid and req.ready are both high; its registers
// are updated at that edge and its result item appears on the rsp channel in
// the next cycle. The single result register holds one item: req.ready stays
// high while the result register is empty or its item is being taken in the
// same cycle, and drops only while a result is held back by rsp.ready. The
// read data is captured in the result register; pin_out, pin_modes_low,
// pin_modes_high and lock_active are driven straight from the state registers,
// which cannot move while a result is waiting, so they always show the state
// after the item on rsp. Reads of BSRR, BRR and the unused index return zero,
// and every write returns zero read data. The lock register takes effect on
// the read that follows the third key write; from then on the nibbles of
// locked pins hold until reset.
module gpio_port_with_config_lock import gpio_lk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	gpio_lk_req_if.sink req,
	gpio_lk_rsp_if.source rsp
);

	bus_op_t op;
	lock_stat_t stat;
	logic accept;
	logic [31:0] crl_q;
	logic [31:0] crh_q;
	logic [NPINS-1:0] odr_q;
	logic [31:0] rd_word;
	logic rsp_valid_s1;
	logic [31:0] read_data_s1;

	assign req.ready = !rsp_valid_s1 || rsp.ready;
	assign accept = req.valid && req.ready;

	always_comb begin
		op.wr_en = accept && (req.opcode == OP_WRITE);
		op.rd_en = accept && (req.opcode == OP_READ);
		op.idx = req.reg_index;
		op.data = req.write_data;
	end

	gpio_lk_lock u_lock (
		.clk(clk),
		.arst_n(arst_n),
		.op(op),
		.stat(stat)
	);

	gpio_lk_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.op(op),
		.stat(stat),
		.crl_q(crl_q),
		.crh_q(crh_q),
		.odr_q(odr_q)
	);

	// Read data comes from the state before the access, as the bus expects.
	always_comb begin
		rd_word = '0;
		if (req.opcode == OP_READ) begin
			case (req.reg_index)
				IDX_CRL: rd_word = crl_q;
				IDX_CRH: rd_word = crh_q;
				IDX_IDR: rd_word = {16'b0, req.pin_levels};
				IDX_ODR: rd_word = {16'b0, odr_q};
				IDX_LCKR: rd_word = {15'b0, stat.key, stat.bits};
				default: rd_word = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s1 <= 1'b0;
		end else if (req.ready) begin
			rsp_valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_s1 <= rd_word;
		end
	end

	assign rsp.valid = rsp_valid_s1;
	assign rsp.read_data = read_data_s1;
	assign rsp.pin_out = odr_q;
	assign rsp.pin_modes_low = crl_q;
	assign rsp.pin_modes_high = crh_q;
	assign rsp.lock_active = stat.key;

`ifndef NO_ASSERTIONS
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_s1) else $error("accepted item produced no result");
	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		op.wr_en |=> read_data_s1 == '0) else $error("write returned nonzero read data");
	a_held_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_s1 && !rsp.ready |=> $stable(odr_q) && $stable(crl_q) && $stable(crh_q))
		else $error("state moved under a waiting result");
`endif

endmodule
